// File: design/amb_pkg.sv
// Shared types, constants and helpers for the adjacency matrix walker.
`default_nettype none
package amb_pkg;

    localparam int NODES  = 16;
    localparam int NODE_W = $clog2(NODES);
    localparam int PTR_W  = $clog2(NODES + 1);
    localparam int CNT_W  = 5;
    localparam int CFG_W  = 5;
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
    localparam logic [IDX_W-1:0] CFG_UNDIRECTED = 1'd1;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(NODES);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_BFS   = 2'd1,
        OP_DFS   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_BFS_POP,
        S_BFS_ADJ,
        S_BFS_NB,
        S_BFS_PUSH,
        S_DFS_NB,
        S_DFS_TOP,
        S_FLUSH,
        S_ERR
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [3:0]       from_node;
        logic [3:0]       to_node;
    } t_in_item;

    typedef struct packed {
        logic [3:0]       node;
        logic             last;
        logic             error;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0] node_count;
        logic             undirected;
    } t_cfg;

    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [NODES-1:0]  wr_data;
        logic              clr;
    } t_adj_req;

    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [NODE_W-1:0] wr_data;
    } t_pend_req;

    typedef struct packed {
        logic      valid;
        t_out_item data;
    } t_emit;

    function automatic logic [NODE_W-1:0] lowest_idx(input logic [NODES-1:0] m);
        logic [NODE_W-1:0] r;
        r = '0;
        for (int j = NODES - 1; j >= 0; j--) begin
            if (m[j]) begin
                r = NODE_W'(j);
            end
        end
        return r;
    endfunction

    function automatic logic [NODES-1:0] node_bit(input logic [NODE_W-1:0] n);
        return {{(NODES-1){1'b0}}, 1'b1} << n;
    endfunction

    function automatic logic [NODES-1:0] live_mask(input logic [CNT_W-1:0] cnt);
        logic [NODES-1:0] m;
        for (int j = 0; j < NODES; j++) begin
            m[j] = (CNT_W'(j) < cnt);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// File: design/adjacency_matrix_bfs_dfs_unit.sv
// Top level: adjacency matrix graph walker, breadth-first and depth-first.
//
//   port group   dir  handshake               payload
//   i_in_*       in   i_in_valid/o_in_ready   amb_pkg::t_in_item
//   o_out_*      out  o_out_valid/i_out_ready amb_pkg::t_out_item
//   i_cfg_*      in   i_cfg_we, no wait       i_cfg_idx, i_cfg_data
//
// Add edge: row read, modify, write, done once more for the reverse side when
// undirected. Clear: all row valid bits drop together. Walk: each visited node
// is paced by registered reads of the pending store and the matrix, for both
// depth-first and breadth-first. Reset is synchronous and clears the matrix at
// once. A stalled output beat holds the walk at its next emit.
`default_nettype none
module adjacency_matrix_bfs_dfs_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire amb_pkg::t_in_item            i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output amb_pkg::t_out_item                o_out_data,
    input  wire logic                         i_cfg_we,
    input  wire logic [amb_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [amb_pkg::CFG_W-1:0]    i_cfg_data
);

    amb_pkg::t_cfg                r_cfg;
    amb_pkg::t_emit               emit;
    amb_pkg::t_adj_req            adj_req;
    amb_pkg::t_pend_req           pend_req;
    logic [amb_pkg::NODES-1:0]    adj_rd_data;
    logic [amb_pkg::NODE_W-1:0]   pend_rd_data;
    logic                         out_free;
    logic                         r_out_valid;
    amb_pkg::t_out_item           r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_count <= amb_pkg::NODE_COUNT_RST;
            r_cfg.undirected <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                amb_pkg::CFG_NODE_COUNT: r_cfg.node_count <= i_cfg_data[amb_pkg::CNT_W-1:0];
                amb_pkg::CFG_UNDIRECTED: r_cfg.undirected <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_out_data <= emit.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    amb_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .i_in_data      (i_in_data),
        .o_in_ready     (o_in_ready),
        .i_out_free     (out_free),
        .o_emit         (emit),
        .o_adj_req      (adj_req),
        .i_adj_rd_data  (adj_rd_data),
        .o_pend_req     (pend_req),
        .i_pend_rd_data (pend_rd_data)
    );

    amb_adj_ram u_adj_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (adj_req),
        .o_rd_data (adj_rd_data)
    );

    amb_pend_ram u_pend_ram (
        .i_clk     (i_clk),
        .i_req     (pend_req),
        .o_rd_data (pend_rd_data)
    );

endmodule
`default_nettype wire

// File: design/amb_adj_ram.sv
// Adjacency row memory with per-row valid bits; invalid rows read as zero.
`default_nettype none
module amb_adj_ram (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire amb_pkg::t_adj_req          i_req,
    output logic [amb_pkg::NODES-1:0]       o_rd_data
);

    logic [amb_pkg::NODES-1:0] r_mem [amb_pkg::NODES];
    logic [amb_pkg::NODES-1:0] r_row_vld;
    logic [amb_pkg::NODES-1:0] r_rd_data;
    logic                      r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_row_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_row_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

// File: design/amb_pend_ram.sv
// Pending node store: queue for breadth-first, stack for depth-first.
`default_nettype none
module amb_pend_ram (
    input  wire logic                       i_clk,
    input  wire amb_pkg::t_pend_req         i_req,
    output logic [amb_pkg::NODE_W-1:0]      o_rd_data
);

    logic [amb_pkg::NODE_W-1:0] r_mem [amb_pkg::NODES];
    logic [amb_pkg::NODE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// File: design/amb_ctrl.sv
// Sequencer for edge updates, matrix clear and both walk orders.
`default_nettype none
module amb_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire amb_pkg::t_cfg              i_cfg,
    input  wire logic                       i_in_valid,
    input  wire amb_pkg::t_in_item          i_in_data,
    output logic                            o_in_ready,
    input  wire logic                       i_out_free,
    output amb_pkg::t_emit                  o_emit,
    output amb_pkg::t_adj_req               o_adj_req,
    input  wire logic [amb_pkg::NODES-1:0]  i_adj_rd_data,
    output amb_pkg::t_pend_req              o_pend_req,
    input  wire logic [amb_pkg::NODE_W-1:0] i_pend_rd_data
);

    amb_pkg::t_state               r_state, n_state;
    logic [amb_pkg::PTR_W-1:0]     r_head, n_head;
    logic [amb_pkg::PTR_W-1:0]     r_tail, n_tail;
    logic [amb_pkg::NODES-1:0]     r_visited, n_visited;
    logic [amb_pkg::NODES-1:0]     r_nb, n_nb;
    logic [amb_pkg::NODE_W-1:0]    r_hold, n_hold;
    logic                          r_hold_vld, n_hold_vld;
    logic [amb_pkg::NODE_W-1:0]    r_a, n_a;
    logic [amb_pkg::NODE_W-1:0]    r_b, n_b;
    logic                          r_second, n_second;

    logic [amb_pkg::NODES-1:0]     mask;
    logic [amb_pkg::NODES-1:0]     nb;
    logic [amb_pkg::NODE_W-1:0]    low;
    logic [amb_pkg::NODE_W-1:0]    push_low;
    logic [amb_pkg::PTR_W-1:0]     tail_m2;
    logic                          from_ok;
    logic                          to_ok;
    logic                          can_emit;

    assign mask     = amb_pkg::live_mask(i_cfg.node_count);
    assign nb       = i_adj_rd_data & mask & ~r_visited;
    assign low      = amb_pkg::lowest_idx(nb);
    assign push_low = amb_pkg::lowest_idx(r_nb);
    assign tail_m2  = r_tail - amb_pkg::PTR_W'(2);
    assign from_ok  = ({1'b0, i_in_data.from_node} < i_cfg.node_count);
    assign to_ok    = ({1'b0, i_in_data.to_node} < i_cfg.node_count);
    assign can_emit = !r_hold_vld || i_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= amb_pkg::S_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_visited  <= '0;
            r_hold_vld <= 1'b0;
            r_second   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_visited  <= n_visited;
            r_hold_vld <= n_hold_vld;
            r_second   <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nb   <= n_nb;
        r_hold <= n_hold;
        r_a    <= n_a;
        r_b    <= n_b;
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_visited  = r_visited;
        n_nb       = r_nb;
        n_hold     = r_hold;
        n_hold_vld = r_hold_vld;
        n_a        = r_a;
        n_b        = r_b;
        n_second   = r_second;
        o_in_ready = 1'b0;
        o_emit     = '0;
        o_adj_req  = '0;
        o_pend_req = '0;

        case (r_state)
            amb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_in_data.op)
                        amb_pkg::OP_CLEAR: begin
                            o_adj_req.clr = 1'b1;
                        end
                        amb_pkg::OP_ADD: begin
                            if (from_ok && to_ok) begin
                                n_a      = i_in_data.from_node;
                                n_b      = i_in_data.to_node;
                                n_second = 1'b0;
                                n_state  = amb_pkg::S_ADD_RD;
                            end
                        end
                        amb_pkg::OP_BFS, amb_pkg::OP_DFS: begin
                            if (!from_ok) begin
                                n_state = amb_pkg::S_ERR;
                            end else begin
                                n_visited          = amb_pkg::node_bit(i_in_data.from_node);
                                n_head             = '0;
                                n_tail             = amb_pkg::PTR_W'(1);
                                n_hold             = i_in_data.from_node;
                                o_pend_req.wr_en   = 1'b1;
                                o_pend_req.wr_addr = '0;
                                o_pend_req.wr_data = i_in_data.from_node;
                                if (i_in_data.op == amb_pkg::OP_DFS) begin
                                    n_hold_vld        = 1'b1;
                                    o_adj_req.rd_en   = 1'b1;
                                    o_adj_req.rd_addr = i_in_data.from_node;
                                    n_state           = amb_pkg::S_DFS_NB;
                                end else begin
                                    n_hold_vld = 1'b0;
                                    n_state    = amb_pkg::S_BFS_POP;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            amb_pkg::S_ADD_RD: begin
                o_adj_req.rd_en   = 1'b1;
                o_adj_req.rd_addr = r_a;
                n_state           = amb_pkg::S_ADD_WR;
            end
            amb_pkg::S_ADD_WR: begin
                o_adj_req.wr_en   = 1'b1;
                o_adj_req.wr_addr = r_a;
                o_adj_req.wr_data = i_adj_rd_data | amb_pkg::node_bit(r_b);
                if (i_cfg.undirected && !r_second) begin
                    n_a      = r_b;
                    n_b      = r_a;
                    n_second = 1'b1;
                    n_state  = amb_pkg::S_ADD_RD;
                end else begin
                    n_state = amb_pkg::S_IDLE;
                end
            end
            amb_pkg::S_BFS_POP: begin
                if (r_head == r_tail) begin
                    n_state = amb_pkg::S_FLUSH;
                end else begin
                    o_pend_req.rd_en   = 1'b1;
                    o_pend_req.rd_addr = r_head[amb_pkg::NODE_W-1:0];
                    n_head             = r_head + amb_pkg::PTR_W'(1);
                    n_state            = amb_pkg::S_BFS_ADJ;
                end
            end
            amb_pkg::S_BFS_ADJ: begin
                o_adj_req.rd_en   = 1'b1;
                o_adj_req.rd_addr = i_pend_rd_data;
                n_state           = amb_pkg::S_BFS_NB;
            end
            amb_pkg::S_BFS_NB: begin
                if (can_emit) begin
                    o_emit.valid     = r_hold_vld;
                    o_emit.data.node = r_hold;
                    n_hold           = i_pend_rd_data;
                    n_hold_vld       = 1'b1;
                    n_nb             = nb;
                    n_visited        = r_visited | nb;
                    n_state          = amb_pkg::S_BFS_PUSH;
                end
            end
            amb_pkg::S_BFS_PUSH: begin
                if (r_nb == '0) begin
                    n_state = amb_pkg::S_BFS_POP;
                end else begin
                    n_nb = r_nb & (r_nb - amb_pkg::NODES'(1));
                    if (r_tail < amb_pkg::PTR_W'(amb_pkg::NODES)) begin
                        o_pend_req.wr_en   = 1'b1;
                        o_pend_req.wr_addr = r_tail[amb_pkg::NODE_W-1:0];
                        o_pend_req.wr_data = push_low;
                        n_tail             = r_tail + amb_pkg::PTR_W'(1);
                    end
                end
            end
            amb_pkg::S_DFS_NB: begin
                if (nb == '0) begin
                    n_tail = r_tail - amb_pkg::PTR_W'(1);
                    if (r_tail == amb_pkg::PTR_W'(1)) begin
                        n_state = amb_pkg::S_FLUSH;
                    end else begin
                        o_pend_req.rd_en   = 1'b1;
                        o_pend_req.rd_addr = tail_m2[amb_pkg::NODE_W-1:0];
                        n_state            = amb_pkg::S_DFS_TOP;
                    end
                end else if (can_emit) begin
                    o_emit.valid      = r_hold_vld;
                    o_emit.data.node  = r_hold;
                    n_hold            = low;
                    n_hold_vld        = 1'b1;
                    n_visited         = r_visited | amb_pkg::node_bit(low);
                    o_adj_req.rd_en   = 1'b1;
                    o_adj_req.rd_addr = low;
                    if (r_tail < amb_pkg::PTR_W'(amb_pkg::NODES)) begin
                        o_pend_req.wr_en   = 1'b1;
                        o_pend_req.wr_addr = r_tail[amb_pkg::NODE_W-1:0];
                        o_pend_req.wr_data = low;
                        n_tail             = r_tail + amb_pkg::PTR_W'(1);
                    end
                end
            end
            amb_pkg::S_DFS_TOP: begin
                o_adj_req.rd_en   = 1'b1;
                o_adj_req.rd_addr = i_pend_rd_data;
                n_state           = amb_pkg::S_DFS_NB;
            end
            amb_pkg::S_FLUSH: begin
                if (i_out_free) begin
                    o_emit.valid     = 1'b1;
                    o_emit.data.node = r_hold;
                    o_emit.data.last = 1'b1;
                    n_hold_vld       = 1'b0;
                    n_state          = amb_pkg::S_IDLE;
                end
            end
            amb_pkg::S_ERR: begin
                if (i_out_free) begin
                    o_emit.valid      = 1'b1;
                    o_emit.data.last  = 1'b1;
                    o_emit.data.error = 1'b1;
                    n_state           = amb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = amb_pkg::S_IDLE;
            end
        endcase
    end

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.valid |-> i_out_free)
        else $error("beat emitted into a full output register");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= amb_pkg::PTR_W'(amb_pkg::NODES))
        else $error("pending store overrun");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == amb_pkg::S_BFS_POP) |-> (r_head <= r_tail))
        else $error("queue head passed tail");

    a_flush_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == amb_pkg::S_FLUSH) |-> r_hold_vld)
        else $error("walk ended with no node held");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_adj_req.wr_en |=> (r_state == amb_pkg::S_ADD_RD) || (r_state == amb_pkg::S_IDLE))
        else $error("matrix write outside edge update");

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for adjacency_matrix_bfs_dfs_unit against a graph predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import amb_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_beat;
    logic                 out_valid;
    logic                 out_ready;
    t_out_item            out_beat;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    // predictor state
    logic [15:0]          adj_rows [16];
    logic [CNT_W-1:0]     cur_count;
    logic                 cur_undirected;
    t_out_item            visits_due [$];

    int                   errors;
    int                   items_sent;
    bit                   in_gaps_on;
    bit                   out_stalls_on;

    adjacency_matrix_bfs_dfs_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("adjacency_matrix_bfs_dfs_unit test failed");
        $finish;
    end

    // Updates the matrix, or appends the visiting order of a walk to visits_due.
    function automatic void apply_item(input t_in_item it);
        int          cnt;
        int          head;
        int          tail;
        int          v;
        int          pick;
        logic [15:0] live;
        logic [15:0] seen;
        logic [15:0] nb;
        logic [3:0]  pend [16];
        t_out_item   beat;
        cnt = (cur_count > 16) ? 16 : int'(cur_count);
        for (int j = 0; j < 16; j++) begin
            live[j] = (j < cnt);
        end
        case (it.op)
            OP_CLEAR: begin
                foreach (adj_rows[j]) adj_rows[j] = '0;
            end
            OP_ADD: begin
                if (int'(it.from_node) < cnt && int'(it.to_node) < cnt) begin
                    adj_rows[it.from_node][it.to_node] = 1'b1;
                    if (cur_undirected) begin
                        adj_rows[it.to_node][it.from_node] = 1'b1;
                    end
                end
            end
            default: begin
                if (int'(it.from_node) >= cnt) begin
                    visits_due.push_back('{node: 4'd0, last: 1'b1, error: 1'b1});
                end else begin
                    seen = '0;
                    seen[it.from_node] = 1'b1;
                    head = 0;
                    tail = 0;
                    pend[tail] = it.from_node;
                    tail++;
                    if (it.op == OP_BFS) begin
                        while (head < tail) begin
                            v = pend[head];
                            head++;
                            nb = adj_rows[v] & live & ~seen;
                            visits_due.push_back('{node: 4'(v), last: 1'b0, error: 1'b0});
                            for (int j = 0; j < 16; j++) begin
                                if (nb[j]) begin
                                    seen[j] = 1'b1;
                                    if (tail < 16) begin
                                        pend[tail] = 4'(j);
                                        tail++;
                                    end
                                end
                            end
                        end
                    end else begin
                        visits_due.push_back('{node: it.from_node, last: 1'b0, error: 1'b0});
                        while (tail > 0) begin
                            v = pend[tail-1];
                            nb = adj_rows[v] & live & ~seen;
                            if (nb == '0) begin
                                tail--;
                            end else begin
                                pick = 0;
                                for (int j = 15; j >= 0; j--) begin
                                    if (nb[j]) pick = j;
                                end
                                seen[pick] = 1'b1;
                                visits_due.push_back('{node: 4'(pick), last: 1'b0,
                                                       error: 1'b0});
                                if (tail < 16) begin
                                    pend[tail] = 4'(pick);
                                    tail++;
                                end
                            end
                        end
                    end
                    beat = visits_due.pop_back();
                    beat.last = 1'b1;
                    visits_due.push_back(beat);
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : check_beats
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (visits_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, got node %0d last %0d error %0d",
                         $time, out_beat.node, out_beat.last, out_beat.error);
            end else begin
                want = visits_due.pop_front();
                if (out_beat !== want) begin
                    errors++;
                    $display({"%0t: beat mismatch, expected node %0d last %0d error %0d,",
                              " got node %0d last %0d error %0d"},
                             $time, want.node, want.last, want.error,
                             out_beat.node, out_beat.last, out_beat.error);
                end
            end
        end
    end

    initial begin
        out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (out_stalls_on && $urandom_range(0, 5) == 0) begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            out_ready = 1'b1;
        end
    end

    task automatic send_item(input t_op op, input logic [3:0] a, input logic [3:0] b);
        if (in_gaps_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_beat  = '{op: op, from_node: a, to_node: b};
        in_valid = 1'b1;
        do @(posedge i_clk); while (!in_ready);
        apply_item(in_beat);
        items_sent++;
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (visits_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_idle();
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we   = 1'b0;
        if (idx == CFG_NODE_COUNT) begin
            cur_count = val;
        end else begin
            cur_undirected = val[0];
        end
    endtask

    task automatic test_empty_graph();
        send_item(OP_BFS, 4'd0, 4'd0);
        send_item(OP_DFS, 4'd15, 4'd15);
    endtask

    task automatic test_directed_edges();
        send_item(OP_ADD, 4'd0, 4'd1);
        send_item(OP_ADD, 4'd0, 4'd15);
        send_item(OP_ADD, 4'd1, 4'd2);
        send_item(OP_ADD, 4'd15, 4'd3);
        send_item(OP_ADD, 4'd2, 4'd0);
        send_item(OP_BFS, 4'd0, 4'd0);
        send_item(OP_DFS, 4'd0, 4'd9);
        send_item(OP_DFS, 4'd15, 4'd0);
    endtask

    // edges past the count are dropped, shrunk counts hide old edges
    task automatic test_count_limits();
        write_reg(CFG_NODE_COUNT, 5'd4);
        send_item(OP_ADD, 4'd2, 4'd9);
        send_item(OP_ADD, 4'd9, 4'd2);
        send_item(OP_BFS, 4'd0, 4'd0);
        send_item(OP_BFS, 4'd9, 4'd0);
        send_item(OP_DFS, 4'd3, 4'd0);
        write_reg(CFG_NODE_COUNT, 5'd0);
        send_item(OP_ADD, 4'd0, 4'd1);
        send_item(OP_DFS, 4'd0, 4'd0);
        write_reg(CFG_NODE_COUNT, 5'd31);
        send_item(OP_BFS, 4'd15, 4'd0);
        write_reg(CFG_NODE_COUNT, 5'd1);
        send_item(OP_BFS, 4'd0, 4'd0);
        send_item(OP_DFS, 4'd1, 4'd0);
    endtask

    task automatic test_undirected();
        write_reg(CFG_NODE_COUNT, 5'd16);
        write_reg(CFG_UNDIRECTED, 5'd1);
        send_item(OP_ADD, 4'd3, 4'd2);
        send_item(OP_ADD, 4'd14, 4'd15);
        send_item(OP_DFS, 4'd2, 4'd0);
        send_item(OP_BFS, 4'd15, 4'd0);
    endtask

    task automatic test_clear();
        send_item(OP_CLEAR, 4'd15, 4'd15);
        send_item(OP_BFS, 4'd0, 4'd0);
        send_item(OP_DFS, 4'd2, 4'd0);
    endtask

    // phases of: new settings, optional clear, random graph, a few walks
    task automatic test_random_graphs(input int n_items);
        int target;
        int eff;
        int n_edges;
        int n_walks;
        logic [CFG_W-1:0] cnt;
        logic [3:0] a;
        logic [3:0] b;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if (items_sent > target - 60) begin
                in_gaps_on    = 1'b0;
                out_stalls_on = 1'b0;
            end
            case ($urandom_range(0, 9))
                0:       cnt = 5'd0;
                1:       cnt = 5'($urandom_range(17, 31));
                2:       cnt = 5'd16;
                default: cnt = 5'($urandom_range(1, 16));
            endcase
            write_reg(CFG_NODE_COUNT, cnt);
            write_reg(CFG_UNDIRECTED, 5'($urandom_range(0, 31)));
            eff = (cnt > 16) ? 16 : int'(cnt);
            if ($urandom_range(0, 2) == 0) begin
                send_item(OP_CLEAR, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            end
            n_edges = $urandom_range(0, 24);
            for (int k = 0; k < n_edges; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_item(t_op'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)));
                end else begin
                    if (eff == 0 || $urandom_range(0, 7) == 0) begin
                        a = 4'($urandom_range(0, 15));
                        b = 4'($urandom_range(0, 15));
                    end else begin
                        a = 4'($urandom_range(0, eff - 1));
                        b = 4'($urandom_range(0, eff - 1));
                    end
                    send_item(OP_ADD, a, b);
                end
            end
            n_walks = $urandom_range(1, 4);
            for (int k = 0; k < n_walks; k++) begin
                if (eff == 0 || $urandom_range(0, 7) == 0) begin
                    a = 4'($urandom_range(0, 15));
                end else begin
                    a = 4'($urandom_range(0, eff - 1));
                end
                send_item($urandom_range(0, 1) ? OP_BFS : OP_DFS, a,
                          4'($urandom_range(0, 15)));
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_beat        = '0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        errors         = 0;
        items_sent     = 0;
        in_gaps_on     = 1'b1;
        out_stalls_on  = 1'b1;
        cur_count      = 5'd16;
        cur_undirected = 1'b0;
        foreach (adj_rows[j]) adj_rows[j] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_graph();
        test_directed_edges();
        test_count_limits();
        test_undirected();
        test_clear();
        test_random_graphs(420);

        wait_idle();
        repeat (30) @(negedge i_clk);
        if (errors == 0 && visits_due.size() == 0) begin
            $display("adjacency_matrix_bfs_dfs_unit test passed");
        end else begin
            $display("adjacency_matrix_bfs_dfs_unit test failed");
        end
        $finish;
    end

endmodule

// File: adjacency_matrix_bfs_dfs_unit.f
design/amb_pkg.sv
design/amb_adj_ram.sv
design/amb_pend_ram.sv
design/amb_ctrl.sv
design/adjacency_matrix_bfs_dfs_unit.sv
tb/sv/tb_top.sv
